// ===== design/grid_gradient_field_core_assert.svh =====
// Assertion macros shared by the checker of the gradient field core.
`ifndef GRID_GRADIENT_FIELD_CORE_ASSERT_SVH
`define GRID_GRADIENT_FIELD_CORE_ASSERT_SVH

`define GGF_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define GGF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`define GGF_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) rst |=> cons) else $error(msg);

`endif

// ===== design/ggf_pkg.sv =====
// Shared types, codes and helpers of the gradient field core.
package ggf_pkg;

   localparam int GRID_X_DEFAULT = 32;
   localparam int GRID_Y_DEFAULT = 32;
   localparam int GRID_Z_DEFAULT = 32;

   localparam int CSR_INDEX_W = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_AXIS       = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_Z_WRAP     = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SLAB_LOWER = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SLAB_UPPER = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_X     = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_Y     = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_Z     = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_INV_CELL   = 4'd7;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;
   localparam logic [1:0] AXIS_NONE = 2'd3;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_ZERO,
      CMD_DERIV,
      CMD_ZAVG
   } cmd_kind_type;

   typedef struct packed {
      logic [1:0]  axis;
      logic        z_wrap;
      logic [5:0]  slab_lower;
      logic [5:0]  slab_upper;
      logic [5:0]  size_x;
      logic [5:0]  size_y;
      logic [5:0]  size_z;
      logic [31:0] inv_cell;
   } cfg_type;

   typedef struct packed {
      logic [4:0] x;
      logic [4:0] y;
      logic [4:0] z;
   } point_type;

   typedef struct packed {
      point_type hi;
      point_type lo;
      logic      one_sided;
   } pair_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic               one_sided;
      point_type          p0_hi;
      point_type          p0_lo;
      point_type          p1_hi;
      point_type          p1_lo;
      logic signed [31:0] wdata;
   } cmd_type;

   function automatic logic [5:0] clamp_size(logic [5:0] s, int unsigned g);
      if (s < 6'd3) return 6'd3;
      if (32'(s) > g) return g[5:0];
      return s;
   endfunction

endpackage

// ===== design/ggf_if.sv =====
// Handshake channel interfaces of the gradient field core.
interface ggf_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic [4:0]         pos_x;
   logic [4:0]         pos_y;
   logic [4:0]         pos_z;
   logic signed [31:0] potential;
   modport source (output valid, op, pos_x, pos_y, pos_z, potential, input ready);
   modport sink (input valid, op, pos_x, pos_y, pos_z, potential, output ready);
endinterface

interface ggf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] field_value;
   modport source (output valid, field_value, input ready);
   modport sink (input valid, field_value, output ready);
endinterface

interface ggf_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ggf_pkg::CSR_INDEX_W-1:0]    index;
   logic [31:0]                        data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== design/ggf_front.sv =====
// Front end: classifies each incoming item into a grid command.
module ggf_front #(
   parameter int GRID_X = ggf_pkg::GRID_X_DEFAULT,
   parameter int GRID_Y = ggf_pkg::GRID_Y_DEFAULT,
   parameter int GRID_Z = ggf_pkg::GRID_Z_DEFAULT
) (
   input  ggf_pkg::cfg_type cfg,
   ggf_req_if.sink          req_port,
   output logic             push_valid,
   output ggf_pkg::cmd_type push_cmd,
   input  logic             push_ready
);

   function automatic ggf_pkg::pair_type make_pair(logic [1:0] axis, logic [4:0] x,
                                                   logic [4:0] y, logic [4:0] z,
                                                   logic [5:0] sz);
      ggf_pkg::pair_type p;
      p.hi.x = x;
      p.hi.y = y;
      p.hi.z = z;
      p.lo = p.hi;
      p.one_sided = 1'b0;
      unique case (axis)
         ggf_pkg::AXIS_X: begin
            p.hi.x = x + 5'd1;
            p.lo.x = x - 5'd1;
         end
         ggf_pkg::AXIS_Y: begin
            p.hi.y = y + 5'd1;
            p.lo.y = y - 5'd1;
         end
         ggf_pkg::AXIS_Z: begin
            if (z == 5'd0) begin
               p.hi.z = 5'd1;
               p.one_sided = 1'b1;
            end else if ({1'b0, z} == sz - 6'd1) begin
               p.lo.z = z - 5'd1;
               p.one_sided = 1'b1;
            end else begin
               p.hi.z = z + 5'd1;
               p.lo.z = z - 5'd1;
            end
         end
         default: begin
         end
      endcase
      return p;
   endfunction

   logic [5:0] sx, sy, sz, xl, xh, sz_last, x6, y6, z6;
   logic       in_window, z_end, load_in_grid;
   ggf_pkg::pair_type pair0, pair1;

   always_comb begin
      sx = ggf_pkg::clamp_size(cfg.size_x, GRID_X);
      sy = ggf_pkg::clamp_size(cfg.size_y, GRID_Y);
      sz = ggf_pkg::clamp_size(cfg.size_z, GRID_Z);
      sz_last = sz - 6'd1;
      xl = (cfg.slab_lower < 6'd1) ? 6'd1 : cfg.slab_lower;
      xh = (cfg.slab_upper < sx - 6'd1) ? cfg.slab_upper : sx - 6'd1;
      x6 = {1'b0, req_port.pos_x};
      y6 = {1'b0, req_port.pos_y};
      z6 = {1'b0, req_port.pos_z};
      in_window = (cfg.axis != ggf_pkg::AXIS_NONE) && (x6 >= xl) && (x6 < xh) &&
                  (y6 >= 6'd1) && (y6 < sy - 6'd1) && (z6 < sz);
      z_end = (z6 == 6'd0) || (z6 == sz_last);
      load_in_grid = (32'(req_port.pos_x) < GRID_X) && (32'(req_port.pos_y) < GRID_Y) &&
                     (32'(req_port.pos_z) < GRID_Z);
      pair0 = make_pair(cfg.axis, req_port.pos_x, req_port.pos_y,
                        z_end ? 5'd0 : req_port.pos_z, sz);
      pair1 = make_pair(cfg.axis, req_port.pos_x, req_port.pos_y, sz_last[4:0], sz);

      push_cmd.one_sided = pair0.one_sided;
      push_cmd.p0_lo = pair0.lo;
      push_cmd.p1_hi = pair1.hi;
      push_cmd.p1_lo = pair1.lo;
      push_cmd.wdata = req_port.potential;
      if (req_port.op == ggf_pkg::OP_LOAD) begin
         push_cmd.kind = ggf_pkg::CMD_LOAD;
         push_cmd.p0_hi.x = req_port.pos_x;
         push_cmd.p0_hi.y = req_port.pos_y;
         push_cmd.p0_hi.z = req_port.pos_z;
      end else begin
         push_cmd.p0_hi = pair0.hi;
         if (!in_window) begin
            push_cmd.kind = ggf_pkg::CMD_ZERO;
         end else if (z_end) begin
            push_cmd.kind = cfg.z_wrap ? ggf_pkg::CMD_ZAVG : ggf_pkg::CMD_ZERO;
         end else begin
            push_cmd.kind = ggf_pkg::CMD_DERIV;
         end
      end
      push_valid = req_port.valid && ((req_port.op == ggf_pkg::OP_QUERY) || load_in_grid);
   end

   assign req_port.ready = push_ready;

endmodule

// ===== design/ggf_cmd_queue.sv =====
// Short command queue between the front end and the back end.
module ggf_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  ggf_pkg::cmd_type push_cmd,
   output logic             push_ready,
   output logic             pop_valid,
   output ggf_pkg::cmd_type pop_cmd,
   input  logic             pop_ready
);

   localparam int PtrW = (ggf_pkg::QUEUE_DEPTH > 1) ? $clog2(ggf_pkg::QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(ggf_pkg::QUEUE_DEPTH + 1);

   ggf_pkg::cmd_type entry_ff [ggf_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
      if (32'(p) == ggf_pkg::QUEUE_DEPTH - 1) return '0;
      return p + PtrW'(1);
   endfunction

   always_comb begin
      push_ready = (32'(count_ff) < ggf_pkg::QUEUE_DEPTH);
      pop_valid = (count_ff != '0);
      pop_cmd = entry_ff[rd_ptr_ff];
      do_push = push_valid && push_ready;
      do_pop = pop_valid && pop_ready;
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff + CntW'(do_push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== design/ggf_back.sv =====
// Back end: potential grid memory, difference, scaling and z-end averaging.
module ggf_back #(
   parameter int GRID_X = ggf_pkg::GRID_X_DEFAULT,
   parameter int GRID_Y = ggf_pkg::GRID_Y_DEFAULT,
   parameter int GRID_Z = ggf_pkg::GRID_Z_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  ggf_pkg::cfg_type cfg,
   input  logic             pop_valid,
   input  ggf_pkg::cmd_type pop_cmd,
   output logic             pop_ready,
   ggf_rsp_if.source        rsp_port
);

   localparam int Depth = GRID_X * GRID_Y * GRID_Z;
   localparam int AddrW = $clog2(Depth);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_LO,
      S_DIFF,
      S_MUL,
      S_RND,
      S_AVG
   } state_type;

   function automatic logic [AddrW-1:0] addr_of(ggf_pkg::point_type p);
      return AddrW'((32'(p.x) * GRID_Y + 32'(p.y)) * GRID_Z + 32'(p.z));
   endfunction

   logic [31:0] mem_ram [Depth];
   logic [31:0] rdata_ff;
   logic [AddrW-1:0] mem_addr;
   logic mem_we;

   state_type          state_ff, state_in;
   ggf_pkg::cmd_type   cur_ff, cur_in;
   logic               pass_ff, pass_in;
   logic               out_valid_ff, out_valid_in;
   logic signed [31:0] out_data_ff, out_data_in;
   logic signed [31:0] hi_ff, hi_in;
   logic signed [32:0] diff_ff, diff_in;
   logic [63:0]        prod_ff, prod_in;
   logic               neg_ff, neg_in;
   logic signed [31:0] val0_ff, val0_in, val1_ff, val1_in;

   logic               out_free, popping;
   logic [32:0]        mag;
   logic [64:0]        rsum, rshift;
   logic signed [31:0] scaled;
   logic signed [32:0] zsum;
   logic [32:0]        zmag, zhalf;
   logic signed [31:0] zavg;

   always_comb begin
      out_free = !out_valid_ff || rsp_port.ready;
      pop_ready = (state_ff == S_IDLE) && ((pop_cmd.kind != ggf_pkg::CMD_ZERO) || out_free);
      popping = pop_valid && pop_ready;

      mag = diff_ff[32] ? 33'(-diff_ff) : 33'(diff_ff);

      rsum = {1'b0, prod_ff} + (cur_ff.one_sided ? 65'h8000 : 65'h10000);
      rshift = cur_ff.one_sided ? (rsum >> 16) : (rsum >> 17);
      if (!neg_ff) begin
         scaled = (rshift > 65'h7FFF_FFFF) ? 32'sh7FFF_FFFF : rshift[31:0];
      end else begin
         scaled = (rshift > 65'h8000_0000) ? 32'sh8000_0000 : -rshift[31:0];
      end

      zsum = 33'(val0_ff) + 33'(val1_ff);
      zmag = zsum[32] ? 33'(-zsum) : 33'(zsum);
      zhalf = (zmag + 33'd1) >> 1;
      zavg = zsum[32] ? -zhalf[31:0] : zhalf[31:0];

      hi_in = hi_ff;
      diff_in = diff_ff;
      prod_in = prod_ff;
      neg_in = neg_ff;

      state_in = state_ff;
      cur_in = cur_ff;
      pass_in = pass_ff;
      val0_in = val0_ff;
      val1_in = val1_ff;
      out_valid_in = out_valid_ff && !rsp_port.ready;
      out_data_in = out_data_ff;
      mem_we = 1'b0;
      mem_addr = addr_of(pop_cmd.p0_hi);

      unique case (state_ff)
         S_IDLE: begin
            if (popping) begin
               cur_in = pop_cmd;
               pass_in = 1'b0;
               unique case (pop_cmd.kind)
                  ggf_pkg::CMD_LOAD: mem_we = 1'b1;
                  ggf_pkg::CMD_ZERO: begin
                     out_valid_in = 1'b1;
                     out_data_in = '0;
                  end
                  default: state_in = S_RD_LO;
               endcase
            end
         end
         S_RD_LO: begin
            mem_addr = addr_of(pass_ff ? cur_ff.p1_lo : cur_ff.p0_lo);
            hi_in = rdata_ff;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            diff_in = 33'(hi_ff) - 33'($signed(rdata_ff));
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in = mag[32] ? {cfg.inv_cell, 32'd0} : 64'(mag[31:0]) * 64'(cfg.inv_cell);
            neg_in = diff_ff[32];
            state_in = S_RND;
         end
         S_RND: begin
            if (cur_ff.kind == ggf_pkg::CMD_ZAVG && !pass_ff) begin
               mem_addr = addr_of(cur_ff.p1_hi);
               val0_in = scaled;
               pass_in = 1'b1;
               state_in = S_RD_LO;
            end else if (cur_ff.kind == ggf_pkg::CMD_ZAVG) begin
               val1_in = scaled;
               state_in = S_AVG;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in = scaled;
               state_in = S_IDLE;
            end
         end
         S_AVG: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in = zavg;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ram[mem_addr] <= pop_cmd.wdata;
      end
      rdata_ff <= mem_ram[mem_addr];
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      hi_ff <= hi_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      neg_ff <= neg_in;
      val0_ff <= val0_in;
      val1_ff <= val1_in;
      out_data_ff <= out_data_in;
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff <= pass_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_port.valid = out_valid_ff;
   assign rsp_port.field_value = out_data_ff;

endmodule

// ===== design/grid_gradient_field_core.sv =====
// A load is written at the edge at which it leaves the queue; a query passes S_RD_LO, S_DIFF,
// S_MUL, S_RND (a periodic z-end query twice, then S_AVG) and its result is registered; a
// zero answer is registered as the query leaves the queue. One load per cycle while the back
// end is idle; no new command is taken during a query, as one grid memory port serves all
// reads of the sequencer. Reset clears the queue, the result valid flag and the registers to
// their defaults; the grid contents stay undefined until loaded, so no clearing pass runs.
module grid_gradient_field_core #(
   parameter int GRID_X = ggf_pkg::GRID_X_DEFAULT,
   parameter int GRID_Y = ggf_pkg::GRID_Y_DEFAULT,
   parameter int GRID_Z = ggf_pkg::GRID_Z_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   ggf_req_if.sink     req_port,
   ggf_rsp_if.source   rsp_port,
   ggf_csr_if.sink     csr_port
);

   ggf_pkg::cfg_type cfg_ff, cfg_in;
   logic             push_valid, push_ready, pop_valid, pop_ready;
   ggf_pkg::cmd_type push_cmd, pop_cmd;

   assign csr_port.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_port.valid) begin
         unique case (csr_port.index)
            ggf_pkg::REG_AXIS:       cfg_in.axis = csr_port.data[1:0];
            ggf_pkg::REG_Z_WRAP:     cfg_in.z_wrap = csr_port.data[0];
            ggf_pkg::REG_SLAB_LOWER: cfg_in.slab_lower = csr_port.data[5:0];
            ggf_pkg::REG_SLAB_UPPER: cfg_in.slab_upper = csr_port.data[5:0];
            ggf_pkg::REG_SIZE_X:     cfg_in.size_x = csr_port.data[5:0];
            ggf_pkg::REG_SIZE_Y:     cfg_in.size_y = csr_port.data[5:0];
            ggf_pkg::REG_SIZE_Z:     cfg_in.size_z = csr_port.data[5:0];
            ggf_pkg::REG_INV_CELL:   cfg_in.inv_cell = csr_port.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis <= ggf_pkg::AXIS_X;
         cfg_ff.z_wrap <= 1'b0;
         cfg_ff.slab_lower <= 6'd0;
         cfg_ff.slab_upper <= 6'd32;
         cfg_ff.size_x <= 6'd32;
         cfg_ff.size_y <= 6'd32;
         cfg_ff.size_z <= 6'd32;
         cfg_ff.inv_cell <= 32'd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ggf_front #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_front (
      .cfg        (cfg_ff),
      .req_port   (req_port),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   ggf_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   ggf_back #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop_ready (pop_ready),
      .rsp_port  (rsp_port)
   );

endmodule

// ===== design/ggf_checker.sv =====
// Port-level checker of the gradient field core and its bind.
`include "grid_gradient_field_core_assert.svh"

module ggf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_field_value,
   input logic        csr_valid,
   input logic        csr_ready
);

   `GGF_ASSERT_NEXT(rsp_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_field_value), "Stalled result changed or was dropped.")
   `GGF_ASSERT_AFTER_RESET(rsp_idle_after_reset, clock, reset, !rsp_valid, "Result valid right after reset.")
   `GGF_ASSERT_ALWAYS(csr_always_taken, clock, reset, csr_valid |-> csr_ready, "Register write was not taken.")

endmodule

bind grid_gradient_field_core ggf_checker u_ggf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_field_value (rsp_port.field_value),
   .csr_valid       (csr_port.valid),
   .csr_ready       (csr_port.ready)
);
